[rtl/whole_word_reference_finder_assert.svh]
// Assertion macros shared by the RTL. Clock and reset names are fixed.
`ifndef WHOLE_WORD_REFERENCE_FINDER_ASSERT_SVH
`define WHOLE_WORD_REFERENCE_FINDER_ASSERT_SVH

// Same-cycle implication.
`define WWRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WWRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wwrf_pkg.sv]
`default_nettype none

package wwrf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned TOKEN_LEN_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] RegTokenBytesLow    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] RegTokenBytesSecond = 3'd1;
  localparam logic [CFG_IDX_W-1:0] RegTokenBytesThird  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] RegTokenBytesHigh   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] RegTokenLength      = 3'd4;

  localparam logic [TOKEN_LEN_W-1:0] TokenLengthReset = 6'd1;

  localparam logic [BYTE_W-1:0] ChrSemicolon = 8'h3B;
  localparam logic [BYTE_W-1:0] ChrQuote     = 8'h22;
  localparam logic [BYTE_W-1:0] ChrBackslash = 8'h5C;
  localparam logic [BYTE_W-1:0] ChrNewline   = 8'h0A;
  localparam logic [BYTE_W-1:0] ChrUnderline = 8'h5F;
  localparam logic [BYTE_W-1:0] ChrDot       = 8'h2E;
  localparam logic [BYTE_W-1:0] ChrBang      = 8'h21;
  localparam logic [BYTE_W-1:0] ChrAt        = 8'h40;
  localparam logic [BYTE_W-1:0] ChrDigit0    = 8'h30;
  localparam logic [BYTE_W-1:0] ChrDigit9    = 8'h39;
  localparam logic [BYTE_W-1:0] ChrUpperA    = 8'h41;
  localparam logic [BYTE_W-1:0] ChrUpperZ    = 8'h5A;
  localparam logic [BYTE_W-1:0] ChrLowerA    = 8'h61;
  localparam logic [BYTE_W-1:0] ChrLowerZ    = 8'h7A;

  typedef enum logic [1:0] {
    ModeCode    = 2'd0,
    ModeComment = 2'd1,
    ModeString  = 2'd2,
    ModeEscape  = 2'd3
  } scan_mode_e;

  // Control side of one step result
  typedef struct packed {
    logic emit;   // a result item leaves for this byte
    logic found;  // whole-word match reported
    logic last;   // byte closed the text
  } res_ctl_t;

  function automatic logic is_symbol(input logic [BYTE_W-1:0] b);
    is_symbol = (b >= ChrDigit0 && b <= ChrDigit9) ||
                (b >= ChrUpperA && b <= ChrUpperZ) ||
                (b >= ChrLowerA && b <= ChrLowerZ) ||
                b == ChrUnderline || b == ChrDot || b == ChrBang || b == ChrAt;
  endfunction

endpackage

`default_nettype wire

[rtl/wwrf_token_regs.sv]
`default_nettype none

module wwrf_token_regs #(
  parameter int unsigned TOKEN_MAX_BYTES = 32,
  parameter int unsigned IDX_W           = 5
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [wwrf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [wwrf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [IDX_W-1:0]                   rd_idx_i,
  output logic      [wwrf_pkg::BYTE_W-1:0]        tok_first_o,
  output logic      [wwrf_pkg::BYTE_W-1:0]        tok_sel_o,
  output logic      [wwrf_pkg::TOKEN_LEN_W-1:0]   tok_len_o
);
  import wwrf_pkg::*;

  localparam int unsigned BytesPerReg = CFG_DATA_W / BYTE_W;
  localparam logic [IDX_W:0] Depth = (IDX_W+1)'(TOKEN_MAX_BYTES);

  logic [TOKEN_MAX_BYTES-1:0][BYTE_W-1:0] tok_q;
  logic [TOKEN_LEN_W-1:0]                 len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      len_q <= TokenLengthReset;
    end else if (cfg_we_i) begin
      for (int k = 0; k < TOKEN_MAX_BYTES; k++) begin
        if (cfg_index_i == CFG_IDX_W'(k / BytesPerReg)) begin
          tok_q[k] <= cfg_data_i[(k % BytesPerReg) * BYTE_W +: BYTE_W];
        end
      end
      if (cfg_index_i == RegTokenLength) begin
        len_q <= cfg_data_i[TOKEN_LEN_W-1:0];
      end
    end
  end

  assign tok_first_o = tok_q[0];
  assign tok_sel_o   = ({1'b0, rd_idx_i} < Depth) ? tok_q[rd_idx_i] : '0;
  assign tok_len_o   = len_q;

endmodule

`default_nettype wire

[rtl/wwrf_scan.sv]
`default_nettype none

module wwrf_scan #(
  parameter int unsigned TOKEN_MAX_BYTES = 32,
  parameter int unsigned POSITION_WIDTH  = 16,
  parameter int unsigned RUN_W           = 6,
  parameter int unsigned IDX_W           = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic [wwrf_pkg::BYTE_W-1:0]       byte_i,
  input  wire logic                              last_i,
  input  wire logic [wwrf_pkg::BYTE_W-1:0]       tok_first_i,
  input  wire logic [wwrf_pkg::BYTE_W-1:0]       tok_sel_i,
  input  wire logic [wwrf_pkg::TOKEN_LEN_W-1:0]  tok_len_i,
  output logic      [IDX_W-1:0]                  rd_idx_o,
  output wwrf_pkg::res_ctl_t                     ctl_o,
  output logic      [POSITION_WIDTH-1:0]         line_o,
  output logic      [POSITION_WIDTH-1:0]         column_o
);
  import wwrf_pkg::*;

  localparam logic [TOKEN_LEN_W-1:0] LenMax = TOKEN_LEN_W'(TOKEN_MAX_BYTES);
  localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

  scan_mode_e                mode_q, mode_d;
  logic [POSITION_WIDTH-1:0] line_q, line_d;
  logic [POSITION_WIDTH-1:0] col_q, col_d;
  logic [POSITION_WIDTH-1:0] start_q, start_d;
  logic [RUN_W-1:0]          len_q, len_d;
  logic                      match_q, match_d;

  logic                      sym, len_ok, close_hit, last_hit;
  logic [TOKEN_LEN_W-1:0]    len_ext, len_d_ext;
  logic [POSITION_WIDTH-1:0] line_inc, col_inc;

  assign rd_idx_o = len_q[IDX_W-1:0];

  always_comb begin
    sym       = is_symbol(byte_i);
    len_ok    = tok_len_i != '0 && tok_len_i <= LenMax;
    len_ext   = TOKEN_LEN_W'(len_q);
    line_inc  = (line_q == PosMax) ? line_q : line_q + 1'b1;
    col_inc   = (col_q == PosMax) ? col_q : col_q + 1'b1;
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    start_d   = start_q;
    len_d     = len_q;
    match_d   = match_q;
    close_hit = 1'b0;

    unique case (mode_q)
      ModeCode: begin
        if (sym) begin
          if (len_q == '0) begin
            start_d = col_q;
            match_d = tok_first_i == byte_i;
            len_d   = RUN_W'(1);
          end else begin
            if (len_ext < tok_len_i && len_ext < LenMax) begin
              match_d = match_q && tok_sel_i == byte_i;
            end else begin
              match_d = 1'b0;
            end
            // saturates one past the longest token
            if (len_ext <= LenMax) begin
              len_d = len_q + 1'b1;
            end
          end
          col_d = col_inc;
        end else begin
          close_hit = len_q != '0 && match_q && len_ok && len_ext == tok_len_i;
          len_d     = '0;
          match_d   = 1'b0;
          if (byte_i == ChrNewline) begin
            line_d = line_inc;
            col_d  = '0;
          end else begin
            if (byte_i == ChrSemicolon) begin
              mode_d = ModeComment;
            end else if (byte_i == ChrQuote) begin
              mode_d = ModeString;
            end
            col_d = col_inc;
          end
        end
      end
      ModeComment, ModeString, ModeEscape: begin
        if (byte_i == ChrNewline) begin
          mode_d = (mode_q == ModeEscape) ? ModeString : ModeCode;
          line_d = line_inc;
          col_d  = '0;
        end else begin
          if (mode_q == ModeEscape) begin
            mode_d = ModeString;
          end else if (mode_q == ModeString && byte_i == ChrBackslash) begin
            mode_d = ModeEscape;
          end else if (mode_q == ModeString && byte_i == ChrQuote) begin
            mode_d = ModeCode;
          end
          col_d = col_inc;
        end
      end
      default: begin
        mode_d = ModeCode;
      end
    endcase

    // a word still open on the final byte is checked too
    len_d_ext = TOKEN_LEN_W'(len_d);
    last_hit  = last_i && !close_hit && len_d != '0 && match_d && len_ok &&
                len_d_ext == tok_len_i;

    ctl_o.found = close_hit || last_hit;
    ctl_o.last  = last_i;
    ctl_o.emit  = close_hit || last_hit || last_i;
    line_o      = ctl_o.found ? line_q : '0;
    column_o    = ctl_o.found ? start_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeCode;
      line_q  <= '0;
      col_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      match_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        mode_q  <= ModeCode;
        line_q  <= '0;
        col_q   <= '0;
        start_q <= '0;
        len_q   <= '0;
        match_q <= 1'b0;
      end else begin
        mode_q  <= mode_d;
        line_q  <= line_d;
        col_q   <= col_d;
        start_q <= start_d;
        len_q   <= len_d;
        match_q <= match_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/whole_word_reference_finder.sv]
// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o    text_byte_i, final_byte_i
// out       source     out_valid_o/out_stall_i  match_found_o, match_line_o,
//                                              match_column_o, end_of_text_o
// cfg       sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// One byte per cycle when the output is not stalled; a byte's result passes the input
// register, then the result register, before it leaves.
// The scan state steps when the input register moves its byte on, so a full result
// register under stall keeps a result byte in the input register; in_stall_o rises.
// A result is made only for a match or for the final byte; other bytes pass freely.
// Reset clears scan state, counters and token registers (token length resets to 1).
`default_nettype none

module whole_word_reference_finder #(
  parameter int unsigned TOKEN_MAX_BYTES = 32,
  parameter int unsigned POSITION_WIDTH  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [wwrf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wwrf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [wwrf_pkg::BYTE_W-1:0]       text_byte_i,
  input  wire logic                              final_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   match_found_o,
  output logic      [POSITION_WIDTH-1:0]         match_line_o,
  output logic      [POSITION_WIDTH-1:0]         match_column_o,
  output logic                                   end_of_text_o
);
  import wwrf_pkg::*;

`include "whole_word_reference_finder_assert.svh"

  localparam int unsigned RunW = $clog2(TOKEN_MAX_BYTES + 2);
  localparam int unsigned IdxW = (TOKEN_MAX_BYTES > 1) ? $clog2(TOKEN_MAX_BYTES) : 1;

  logic                      s1_valid_q;
  logic [BYTE_W-1:0]         s1_byte_q;
  logic                      s1_last_q;
  logic                      step;

  logic                      out_valid_q;
  logic                      found_q, eot_q;
  logic [POSITION_WIDTH-1:0] line_q, col_q;

  logic [BYTE_W-1:0]         tok_first, tok_sel;
  logic [TOKEN_LEN_W-1:0]    tok_len;
  logic [IdxW-1:0]           rd_idx;
  res_ctl_t                  ctl;
  logic [POSITION_WIDTH-1:0] res_line, res_col;

  wwrf_token_regs #(
    .TOKEN_MAX_BYTES(TOKEN_MAX_BYTES),
    .IDX_W          (IdxW)
  ) u_token (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rd_idx_i   (rd_idx),
    .tok_first_o(tok_first),
    .tok_sel_o  (tok_sel),
    .tok_len_o  (tok_len)
  );

  wwrf_scan #(
    .TOKEN_MAX_BYTES(TOKEN_MAX_BYTES),
    .POSITION_WIDTH (POSITION_WIDTH),
    .RUN_W          (RunW),
    .IDX_W          (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (s1_byte_q),
    .last_i     (s1_last_q),
    .tok_first_i(tok_first),
    .tok_sel_i  (tok_sel),
    .tok_len_i  (tok_len),
    .rd_idx_o   (rd_idx),
    .ctl_o      (ctl),
    .line_o     (res_line),
    .column_o   (res_col)
  );

  // byte moves on unless it makes a result and the result register is stuck
  assign step       = s1_valid_q && (!ctl.emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= final_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && ctl.emit) begin
      found_q <= ctl.found;
      eot_q   <= ctl.last;
      line_q  <= res_line;
      col_q   <= res_col;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = found_q;
  assign match_line_o   = line_q;
  assign match_column_o = col_q;
  assign end_of_text_o  = eot_q;

  `WWRF_ASSERT_NOW(a_result_has_cause, out_valid_o && !match_found_o, end_of_text_o,
    "result without match or end of text")
  `WWRF_ASSERT_NOW(a_nomatch_zero, out_valid_o && !match_found_o,
    match_line_o == '0 && match_column_o == '0, "position on a result without match")
  `WWRF_ASSERT_NEXT(a_s1_holds, s1_valid_q && !step,
    s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q), "held input byte lost")
  `WWRF_ASSERT_NOW(a_empty_no_stall, !s1_valid_q, !in_stall_o,
    "input stalled with empty input register")

endmodule

`default_nettype wire
